// ===== hdl/slpg_pkg.sv =====
// Shared types, codes and per-pattern constants for the status LED pattern generator.
package slpg_pkg;

  localparam logic [2:0] MOOD_ATTENTION = 3'd1;
  localparam logic [2:0] MOOD_ERROR     = 3'd2;
  localparam logic [2:0] MOOD_HEART     = 3'd3;
  localparam logic [2:0] MOOD_DIZZY     = 3'd4;
  localparam logic [2:0] MOOD_CELEBRATE = 3'd5;
  localparam logic [2:0] MOOD_WORK      = 3'd6;

  localparam logic        CFG_URGENT    = 1'b0;
  localparam logic        CFG_INSISTENT = 1'b1;
  localparam logic [31:0] URGENT_RST    = 32'd45000;
  localparam logic [31:0] INSISTENT_RST = 32'd15000;

  localparam logic [63:0] TWO_POW_32 = 64'h1_0000_0000;
  localparam logic [31:0] TWO_POW_24 = 32'h0100_0000;

  // floor(2^32 / period): quotient estimate is exact or one low
  localparam logic [24:0] PRECIP_240  = 25'(TWO_POW_32 / 64'd240);
  localparam logic [24:0] PRECIP_360  = 25'(TWO_POW_32 / 64'd360);
  localparam logic [24:0] PRECIP_500  = 25'(TWO_POW_32 / 64'd500);
  localparam logic [24:0] PRECIP_520  = 25'(TWO_POW_32 / 64'd520);
  localparam logic [24:0] PRECIP_600  = 25'(TWO_POW_32 / 64'd600);
  localparam logic [24:0] PRECIP_900  = 25'(TWO_POW_32 / 64'd900);
  localparam logic [24:0] PRECIP_1100 = 25'(TWO_POW_32 / 64'd1100);
  localparam logic [24:0] PRECIP_1500 = 25'(TWO_POW_32 / 64'd1500);
  localparam logic [24:0] PRECIP_1800 = 25'(TWO_POW_32 / 64'd1800);

  // floor(2^24 / half period) for the breath scaling
  localparam logic [16:0] HRECIP_250 = 17'(TWO_POW_24 / 32'd250);
  localparam logic [16:0] HRECIP_550 = 17'(TWO_POW_24 / 32'd550);
  localparam logic [16:0] HRECIP_750 = 17'(TWO_POW_24 / 32'd750);
  localparam logic [16:0] HRECIP_900 = 17'(TWO_POW_24 / 32'd900);

  typedef struct packed {
    logic [31:0] now_ms;
    logic [2:0]  mood;
    logic [1:0]  intensity;
    logic [31:0] wait_start_ms;
    logic        silenced;
  } cmd_t;

  typedef struct packed {
    logic       red_on;
    logic       green_on;
    logic       blue_on;
    logic       use_level;
    logic [6:0] level;
  } result_t;

  typedef enum logic [2:0] {
    KIND_DARK,
    KIND_SOLID,
    KIND_BLINK,
    KIND_BREATH,
    KIND_HEART
  } kind_t;

  typedef enum logic [3:0] {
    PER_240,
    PER_360,
    PER_500,
    PER_520,
    PER_600,
    PER_900,
    PER_1100,
    PER_1500,
    PER_1800
  } per_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic        red;
    logic        green;
    logic        blue;
    per_t        per;
    logic [31:0] now_ms;
  } mode_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic        red;
    logic        green;
    logic        blue;
    per_t        per;
    logic [10:0] ph;
    logic [9:0]  fold;
  } phase_t;

  function automatic logic [10:0] per_len(per_t p);
    logic [10:0] v;
    unique case (p)
      PER_240:  v = 11'd240;
      PER_360:  v = 11'd360;
      PER_500:  v = 11'd500;
      PER_520:  v = 11'd520;
      PER_600:  v = 11'd600;
      PER_900:  v = 11'd900;
      PER_1100: v = 11'd1100;
      PER_1500: v = 11'd1500;
      PER_1800: v = 11'd1800;
      default:  v = 11'd900;
    endcase
    return v;
  endfunction

  function automatic logic [24:0] per_recip(per_t p);
    logic [24:0] v;
    unique case (p)
      PER_240:  v = PRECIP_240;
      PER_360:  v = PRECIP_360;
      PER_500:  v = PRECIP_500;
      PER_520:  v = PRECIP_520;
      PER_600:  v = PRECIP_600;
      PER_900:  v = PRECIP_900;
      PER_1100: v = PRECIP_1100;
      PER_1500: v = PRECIP_1500;
      PER_1800: v = PRECIP_1800;
      default:  v = PRECIP_900;
    endcase
    return v;
  endfunction

  function automatic logic [9:0] per_half(per_t p);
    return 10'(per_len(p) >> 1);
  endfunction

  // on time of a blink pattern
  function automatic logic [8:0] per_on(per_t p);
    logic [8:0] v;
    unique case (p)
      PER_240: v = 9'd120;
      PER_360: v = 9'd180;
      PER_520: v = 9'd300;
      PER_600: v = 9'd300;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] per_hrecip(per_t p);
    logic [16:0] v;
    unique case (p)
      PER_500:  v = HRECIP_250;
      PER_1100: v = HRECIP_550;
      PER_1500: v = HRECIP_750;
      PER_1800: v = HRECIP_900;
      default:  v = HRECIP_900;
    endcase
    return v;
  endfunction

  // breath floor level
  function automatic logic [6:0] per_lo(per_t p);
    logic [6:0] v;
    unique case (p)
      PER_500:  v = 7'd40;
      PER_1100: v = 7'd10;
      PER_1500: v = 7'd8;
      PER_1800: v = 7'd6;
      default:  v = 7'd0;
    endcase
    return v;
  endfunction

  // breath swing, peak minus floor
  function automatic logic [6:0] per_span(per_t p);
    logic [6:0] v;
    unique case (p)
      PER_500:  v = 7'd60;
      PER_1100: v = 7'd90;
      PER_1500: v = 7'd92;
      PER_1800: v = 7'd84;
      default:  v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/slpg_mode.sv =====
// Front stages: wait time, threshold compare and pattern decode per mood.
module slpg_mode (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  slpg_pkg::cmd_t      cmd,
  input  logic [31:0]         urgent_after_ms,
  input  logic [31:0]         insistent_after_ms,
  output slpg_pkg::mode_t     mode
);

  logic           valid1;
  slpg_pkg::cmd_t cmd1;
  logic [31:0]    waited1;
  logic [31:0]    waited_next;
  slpg_pkg::mode_t mode_next;

  // a zero start time means no wait at all
  assign waited_next = (cmd.wait_start_ms != 32'd0) ? (cmd.now_ms - cmd.wait_start_ms) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    cmd1    <= cmd;
    waited1 <= waited_next;
  end

  always_comb begin
    mode_next        = '0;
    mode_next.valid  = valid1;
    mode_next.kind   = slpg_pkg::KIND_DARK;
    mode_next.per    = slpg_pkg::PER_900;
    mode_next.now_ms = cmd1.now_ms;
    if (!cmd1.silenced) begin
      unique case (cmd1.mood)
        slpg_pkg::MOOD_ATTENTION: begin
          mode_next.red   = 1'b1;
          mode_next.green = 1'b1;
          // urgent threshold wins when both are crossed
          if (waited1 > urgent_after_ms) begin
            mode_next.kind = slpg_pkg::KIND_BLINK;
            mode_next.per  = slpg_pkg::PER_240;
          end else if (waited1 > insistent_after_ms) begin
            mode_next.kind = slpg_pkg::KIND_BLINK;
            mode_next.per  = slpg_pkg::PER_600;
          end else begin
            mode_next.kind = slpg_pkg::KIND_BREATH;
            mode_next.per  = slpg_pkg::PER_1500;
          end
        end
        slpg_pkg::MOOD_ERROR: begin
          mode_next.red  = 1'b1;
          mode_next.kind = slpg_pkg::KIND_BLINK;
          mode_next.per  = slpg_pkg::PER_360;
        end
        slpg_pkg::MOOD_HEART: begin
          mode_next.red  = 1'b1;
          mode_next.blue = 1'b1;
          mode_next.kind = slpg_pkg::KIND_HEART;
          mode_next.per  = slpg_pkg::PER_900;
        end
        slpg_pkg::MOOD_DIZZY: begin
          mode_next.red  = 1'b1;
          mode_next.blue = 1'b1;
          mode_next.kind = slpg_pkg::KIND_SOLID;
        end
        slpg_pkg::MOOD_CELEBRATE: begin
          mode_next.green = 1'b1;
          mode_next.kind  = slpg_pkg::KIND_BREATH;
          mode_next.per   = slpg_pkg::PER_500;
        end
        slpg_pkg::MOOD_WORK: begin
          mode_next.blue = 1'b1;
          if (cmd1.intensity[1]) begin
            mode_next.green = 1'b1;
            mode_next.kind  = slpg_pkg::KIND_BLINK;
            mode_next.per   = slpg_pkg::PER_520;
          end else if (cmd1.intensity[0]) begin
            mode_next.kind = slpg_pkg::KIND_BREATH;
            mode_next.per  = slpg_pkg::PER_1100;
          end else begin
            mode_next.kind = slpg_pkg::KIND_BREATH;
            mode_next.per  = slpg_pkg::PER_1800;
          end
        end
        default: begin
          mode_next.kind = slpg_pkg::KIND_DARK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else begin
      mode <= mode_next;
    end
  end

endmodule

// ===== hdl/slpg_phase.sv =====
// Phase stages: timestamp modulo the pattern period and the triangle fold.
module slpg_phase (
  input  logic             clk,
  input  logic             rst,
  input  slpg_pkg::mode_t  mode,
  output slpg_pkg::phase_t phase
);

  slpg_pkg::mode_t mode3;
  slpg_pkg::mode_t mode4;
  logic [24:0]     quot3;
  logic [11:0]     rraw4;
  logic [56:0]     prod;
  logic [35:0]     qp;
  logic [11:0]     rraw_next;
  logic [10:0]     len;
  logic [9:0]      half;
  logic [10:0]     ph;
  logic [9:0]      fold;
  slpg_pkg::phase_t phase_next;

  // quotient estimate by reciprocal, exact or one low
  assign prod = 57'(mode.now_ms) * 57'(slpg_pkg::per_recip(mode.per));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode3 <= '0;
    end else begin
      mode3 <= mode;
    end
  end

  always_ff @(posedge clk) begin
    quot3 <= prod[56:32];
  end

  // remainder below twice the period, so the low 12 bits suffice
  assign qp        = 36'(quot3) * 36'(slpg_pkg::per_len(mode3.per));
  assign rraw_next = mode3.now_ms[11:0] - qp[11:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode4 <= '0;
    end else begin
      mode4 <= mode3;
    end
  end

  always_ff @(posedge clk) begin
    rraw4 <= rraw_next;
  end

  assign len  = slpg_pkg::per_len(mode4.per);
  assign half = slpg_pkg::per_half(mode4.per);

  always_comb begin
    ph = (rraw4 >= {1'b0, len}) ? 11'(rraw4 - {1'b0, len}) : rraw4[10:0];
    // fold the second half of the period back down
    fold = (ph < {1'b0, half}) ? ph[9:0] : 10'(len - ph);
    phase_next       = '0;
    phase_next.valid = mode4.valid;
    phase_next.kind  = mode4.kind;
    phase_next.red   = mode4.red;
    phase_next.green = mode4.green;
    phase_next.blue  = mode4.blue;
    phase_next.per   = mode4.per;
    phase_next.ph    = ph;
    phase_next.fold  = fold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else begin
      phase <= phase_next;
    end
  end

endmodule

// ===== hdl/slpg_level.sv =====
// Back stages: blink and beat decode, breath scaling and the result register.
module slpg_level (
  input  logic              clk,
  input  logic              rst,
  input  slpg_pkg::phase_t  phase,
  output logic              done,
  output slpg_pkg::result_t result
);

  logic              valid6;
  logic              valid7;
  logic              valid8;
  slpg_pkg::result_t base6;
  slpg_pkg::result_t base7;
  slpg_pkg::result_t base8;
  logic              breath6;
  logic              breath7;
  logic              breath8;
  slpg_pkg::per_t    per6;
  slpg_pkg::per_t    per7;
  slpg_pkg::per_t    per8;
  logic [16:0]       x6;
  logic [16:0]       x7;
  logic [6:0]        quot7;
  logic [6:0]        quot8;
  logic [16:0]       rem8;
  slpg_pkg::result_t base_next;
  logic [16:0]       x_next;
  logic [33:0]       hprod;
  logic [16:0]       qh;
  logic [9:0]        half8;
  logic [6:0]        quot_fix;
  slpg_pkg::result_t result_next;

  always_comb begin
    base_next = '0;
    x_next    = 17'(slpg_pkg::per_span(phase.per)) * 17'(phase.fold);
    unique case (phase.kind)
      slpg_pkg::KIND_SOLID: begin
        base_next.red_on   = phase.red;
        base_next.green_on = phase.green;
        base_next.blue_on  = phase.blue;
      end
      slpg_pkg::KIND_BLINK: begin
        // dark once the on time is over
        if (phase.ph < 11'(slpg_pkg::per_on(phase.per))) begin
          base_next.red_on   = phase.red;
          base_next.green_on = phase.green;
          base_next.blue_on  = phase.blue;
        end
      end
      slpg_pkg::KIND_HEART: begin
        base_next.red_on    = phase.red;
        base_next.green_on  = phase.green;
        base_next.blue_on   = phase.blue;
        base_next.use_level = 1'b1;
        if (phase.ph < 11'd110) begin
          base_next.level = 7'd100;
        end else if (phase.ph < 11'd220) begin
          base_next.level = 7'd20;
        end else if (phase.ph < 11'd330) begin
          base_next.level = 7'd70;
        end else begin
          base_next.level = 7'd10;
        end
      end
      slpg_pkg::KIND_BREATH: begin
        base_next.red_on    = phase.red;
        base_next.green_on  = phase.green;
        base_next.blue_on   = phase.blue;
        base_next.use_level = 1'b1;
      end
      default: begin
        base_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid6 <= 1'b0;
      valid7 <= 1'b0;
      valid8 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid6 <= phase.valid;
      valid7 <= valid6;
      valid8 <= valid7;
      done   <= valid8;
    end
  end

  // quotient by half period: reciprocal estimate, then one correction
  assign hprod = 34'(x6) * 34'(slpg_pkg::per_hrecip(per6));
  assign half8 = slpg_pkg::per_half(per8);
  assign qh    = 17'(quot7) * 17'(slpg_pkg::per_half(per7));

  always_ff @(posedge clk) begin
    base6   <= base_next;
    breath6 <= (phase.kind == slpg_pkg::KIND_BREATH);
    per6    <= phase.per;
    x6      <= x_next;

    base7   <= base6;
    breath7 <= breath6;
    per7    <= per6;
    x7      <= x6;
    quot7   <= hprod[30:24];

    base8   <= base7;
    breath8 <= breath7;
    per8    <= per7;
    quot8   <= quot7;
    rem8    <= x7 - qh;
  end

  always_comb begin
    quot_fix    = quot8 + ((rem8 >= 17'(half8)) ? 7'd1 : 7'd0);
    result_next = base8;
    if (breath8) begin
      result_next.level = slpg_pkg::per_lo(per8) + quot_fix;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

// ===== hdl/status_led_pattern_generator.sv =====
// Top level of the status LED pattern generator: config registers and pipeline.
//
// Use: drive cmd and raise start; the item is taken at each rising edge where
// start is high and busy is low. busy is high only during reset, so one item
// can be taken every cycle. Each item yields one result: done rises with the
// final level-add register and stays high for one cycle with result
// valid, in the order the items came in. The receiver cannot hold results off
// and nothing inside waits on it.
// The pipeline has nine register stages: wait time, mood decode, period
// quotient by reciprocal multiply, remainder, remainder fix and triangle fold,
// blink/beat decode and swing multiply, half-period quotient, its remainder,
// and the final level add. Throughput is one item per cycle.
// Configuration: cfg_wr_en writes cfg_data into the register picked by
// cfg_addr (0 urgent_after_ms, 1 insistent_after_ms) at the clock edge; write
// only while no item is in flight.
// Reset (rst, synchronous) restores 45000 and 15000 ms thresholds and empties
// the pipeline; no done strobe follows for items taken before reset.
module status_led_pattern_generator (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  slpg_pkg::cmd_t    cmd,
  input  logic              cfg_wr_en,
  input  logic              cfg_addr,
  input  logic [31:0]       cfg_data,
  output logic              done,
  output slpg_pkg::result_t result
);

  logic             accept;
  logic [31:0]      urgent_after_ms;
  logic [31:0]      insistent_after_ms;
  slpg_pkg::mode_t  mode;
  slpg_pkg::phase_t phase;

  assign busy   = rst;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      urgent_after_ms    <= slpg_pkg::URGENT_RST;
      insistent_after_ms <= slpg_pkg::INSISTENT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        slpg_pkg::CFG_URGENT:    urgent_after_ms    <= cfg_data;
        slpg_pkg::CFG_INSISTENT: insistent_after_ms <= cfg_data;
        default:                 urgent_after_ms    <= urgent_after_ms;
      endcase
    end
  end

  slpg_mode u_mode (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .cmd                (cmd),
    .urgent_after_ms    (urgent_after_ms),
    .insistent_after_ms (insistent_after_ms),
    .mode               (mode)
  );

  slpg_phase u_phase (
    .clk   (clk),
    .rst   (rst),
    .mode  (mode),
    .phase (phase)
  );

  slpg_level u_level (
    .clk    (clk),
    .rst    (rst),
    .phase  (phase),
    .done   (done),
    .result (result)
  );

endmodule
